FILE: rtl/lmnu_pkg.sv
// Shared types, codes and constants for the landmark map nearest-update unit.
`default_nettype none
package lmnu_pkg;

    localparam int MAP_DEPTH_DEF = 64;

    localparam logic [1:0] FUNC_LANDMARK = 2'd0;
    localparam logic [1:0] FUNC_FRAME    = 2'd1;
    localparam logic [1:0] FUNC_READ     = 2'd2;

    localparam logic [15:0] MATCH_RADIUS_RST = 16'd512;
    localparam logic [15:0] RANGE_LIMIT_RST  = 16'd3072;

    localparam logic [3:0] COL_UNKNOWN_NEG = 4'hF;
    localparam logic [3:0] COL_UNKNOWN_POS = 4'd4;
    localparam logic [2:0] ENC_UNKNOWN_NEG = 3'b111;

    localparam int REG_MATCH_RADIUS = 0;
    localparam int REG_RANGE_LIMIT  = 1;

    typedef enum logic [2:0] {
        ACT_OOR   = 3'd0,
        ACT_INS   = 3'd1,
        ACT_DUP   = 3'd2,
        ACT_REP   = 3'd3,
        ACT_FULL  = 3'd4,
        ACT_READ  = 3'd5,
        ACT_FRAME = 3'd6
    } lmnu_act_t;

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_RANGE = 3'd1,
        MUL_ROT1  = 3'd2,
        MUL_ROT2  = 3'd3,
        MUL_DIST  = 3'd4
    } lmnu_mul_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [23:0] local_x;
        logic signed [23:0] local_y;
        logic signed [3:0]  colour_code;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
        logic [5:0]         read_index;
    } lmnu_in_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         slot;
        logic [6:0]         entry_total;
        logic signed [23:0] map_x;
        logic signed [23:0] map_y;
        logic signed [3:0]  entry_colour;
        logic               entry_valid;
    } lmnu_out_t;

    typedef struct packed {
        logic      load_in;
        lmnu_mul_t mul_op;
        logic      gx_ld;
        logic      gy_ld;
        logic      scan_rd;
        logic      mv_rd;
        logic      ri_rd;
        logic      clr_first;
        logic      cnt_dec;
        logic      append;
        logic      out_ld;
        lmnu_act_t act;
    } lmnu_cmd_t;

    typedef struct packed {
        logic oor;
        logic match;
        logic dup;
        logic busy;
        logic first;
        logic out_free;
    } lmnu_sts_t;

endpackage
`default_nettype wire

FILE: rtl/lmnu_regs.sv
// Configuration register file with APB-style access and squared thresholds.
`default_nettype none
module lmnu_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [31:0] match_sq,
    output logic      [31:0] range_sq
);
    logic [15:0] match_radius_reg;
    logic [15:0] range_limit_reg;
    logic [31:0] match_sq_reg;
    logic [31:0] range_sq_reg;
    logic        wr_en;
    logic        sel_range;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign sel_range = (paddr[2] == 1'(lmnu_pkg::REG_RANGE_LIMIT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_radius_reg <= lmnu_pkg::MATCH_RADIUS_RST;
            range_limit_reg  <= lmnu_pkg::RANGE_LIMIT_RST;
        end else if (wr_en) begin
            if (sel_range) begin
                range_limit_reg <= pwdata[15:0];
            end else begin
                match_radius_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        match_sq_reg <= 32'(match_radius_reg) * 32'(match_radius_reg);
        range_sq_reg <= 32'(range_limit_reg) * 32'(range_limit_reg);
    end

    always_comb begin
        if (sel_range) begin
            prdata = 32'(range_limit_reg);
        end else begin
            prdata = 32'(match_radius_reg);
        end
    end

    assign match_sq = match_sq_reg;
    assign range_sq = range_sq_reg;
endmodule
`default_nettype wire

FILE: rtl/lmnu_dp.sv
// Datapath: operand registers, two multipliers, entry memory, scan pipeline, result register.
`default_nettype none
module lmnu_dp #(
    parameter int MAP_DEPTH = lmnu_pkg::MAP_DEPTH_DEF,
    parameter int AW = $clog2(MAP_DEPTH),
    parameter int CW = $clog2(MAP_DEPTH + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lmnu_pkg::lmnu_in_t  in_data,
    input  wire lmnu_pkg::lmnu_cmd_t cmd,
    input  wire logic [AW-1:0]       idx,
    input  wire logic [31:0]         match_sq,
    input  wire logic [31:0]         range_sq,
    output lmnu_pkg::lmnu_sts_t      sts,
    output logic [CW-1:0]            count,
    output logic [AW-1:0]            best_idx,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lmnu_pkg::lmnu_out_t      m_payload
);
    localparam int SW = (AW > 6) ? AW : 6;
    localparam int TW = (CW > 7) ? CW : 7;
    localparam int RW = (AW > 6) ? AW : 6;

    logic signed [23:0] lx_reg, ly_reg, px_reg, py_reg, gx_reg, gy_reg;
    logic signed [15:0] c_reg, s_reg;
    logic [3:0]         col_reg;
    logic [5:0]         ri_reg;
    logic [3:0]         col_norm;

    logic signed [23:0] mem_x [MAP_DEPTH];
    logic signed [23:0] mem_y [MAP_DEPTH];
    logic [2:0]         mem_c [MAP_DEPTH];
    logic signed [23:0] rdx_reg, rdy_reg;
    logic [2:0]         rdc_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [RW-1:0]      ri_wide;

    lmnu_pkg::lmnu_mul_t mul_sel;
    logic signed [24:0] a0, a1, b0, b1, dx, dy;
    logic signed [49:0] pa_reg, pb_reg;
    logic [49:0]        psum;
    logic signed [49:0] rot_sum, rot_rnd;
    logic signed [35:0] rot_q;
    logic signed [36:0] rot_w;
    logic signed [23:0] rot_sat;

    logic               p1_v_reg, p2_v_reg;
    logic [AW-1:0]      p1_idx_reg, p2_idx_reg;
    logic [2:0]         p2_col_reg;
    logic [49:0]        best_reg;
    logic [AW-1:0]      bi_reg;
    logic [2:0]         best_col_reg;

    logic               mv_v_reg;
    logic [AW-1:0]      mv_addr_reg;

    logic [CW-1:0]      count_reg;
    logic               first_reg;
    logic               full;
    logic               unknown;
    logic               rd_ok;

    logic               m_valid_reg;
    lmnu_pkg::lmnu_out_t out_reg, res;
    logic [SW-1:0]      slot_cnt, slot_bi;
    logic [TW-1:0]      tot_cnt, tot_inc, ri_cmp;

    function automatic logic [3:0] dec_col(input logic [2:0] e);
        if (e == lmnu_pkg::ENC_UNKNOWN_NEG) begin
            return lmnu_pkg::COL_UNKNOWN_NEG;
        end
        return {1'b0, e};
    endfunction

    always_comb begin
        if (in_data.colour_code[3]) begin
            col_norm = lmnu_pkg::COL_UNKNOWN_NEG;
        end else if (in_data.colour_code > 4'sd4) begin
            col_norm = lmnu_pkg::COL_UNKNOWN_POS;
        end else begin
            col_norm = in_data.colour_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lx_reg  <= in_data.local_x;
            ly_reg  <= in_data.local_y;
            px_reg  <= in_data.pose_x;
            py_reg  <= in_data.pose_y;
            c_reg   <= in_data.cos_yaw;
            s_reg   <= in_data.sin_yaw;
            col_reg <= col_norm;
            ri_reg  <= in_data.read_index;
        end
    end

    // multiplier operand select
    assign dx      = 25'(gx_reg) - 25'(rdx_reg);
    assign dy      = 25'(gy_reg) - 25'(rdy_reg);
    assign mul_sel = p1_v_reg ? lmnu_pkg::MUL_DIST : cmd.mul_op;

    always_comb begin
        case (mul_sel)
            lmnu_pkg::MUL_RANGE: begin
                a0 = 25'(lx_reg); a1 = 25'(lx_reg); b0 = 25'(ly_reg); b1 = 25'(ly_reg);
            end
            lmnu_pkg::MUL_ROT1: begin
                a0 = 25'(lx_reg); a1 = 25'(c_reg); b0 = 25'(ly_reg); b1 = 25'(s_reg);
            end
            lmnu_pkg::MUL_ROT2: begin
                a0 = 25'(lx_reg); a1 = 25'(s_reg); b0 = 25'(ly_reg); b1 = 25'(c_reg);
            end
            lmnu_pkg::MUL_DIST: begin
                a0 = dx; a1 = dx; b0 = dy; b1 = dy;
            end
            default: begin
                a0 = '0; a1 = '0; b0 = '0; b1 = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pa_reg <= 50'(a0) * 50'(a1);
        pb_reg <= 50'(b0) * 50'(b1);
    end

    assign psum = 50'(pa_reg + pb_reg);

    // rotate, round to nearest, translate, saturate
    always_comb begin
        rot_sum = cmd.gx_ld ? (pa_reg - pb_reg) : (pa_reg + pb_reg);
        rot_rnd = rot_sum + 50'sd8192;
        rot_q   = 36'(rot_rnd >>> 14);
        rot_w   = 37'(rot_q) + (cmd.gx_ld ? 37'(px_reg) : 37'(py_reg));
        if (rot_w > 37'sd8388607) begin
            rot_sat = 24'sh7FFFFF;
        end else if (rot_w < -37'sd8388608) begin
            rot_sat = -24'sh800000;
        end else begin
            rot_sat = rot_w[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.gx_ld) begin
            gx_reg <= rot_sat;
        end
        if (cmd.gy_ld) begin
            gy_reg <= rot_sat;
        end
    end

    // entry memory
    assign ri_wide = RW'(ri_reg);
    assign rd_en   = cmd.scan_rd || cmd.mv_rd || cmd.ri_rd;
    assign rd_addr = cmd.ri_rd ? ri_wide[AW-1:0] : idx;
    assign full    = (count_reg == CW'(MAP_DEPTH));

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdx_reg <= mem_x[rd_addr];
            rdy_reg <= mem_y[rd_addr];
            rdc_reg <= mem_c[rd_addr];
        end
        if (mv_v_reg) begin
            mem_x[mv_addr_reg] <= rdx_reg;
            mem_y[mv_addr_reg] <= rdy_reg;
            mem_c[mv_addr_reg] <= rdc_reg;
        end else if (cmd.append && !full) begin
            mem_x[count_reg[AW-1:0]] <= gx_reg;
            mem_y[count_reg[AW-1:0]] <= gy_reg;
            mem_c[count_reg[AW-1:0]] <= col_reg[2:0];
        end
    end

    // scan and compaction pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            mv_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= cmd.scan_rd;
            p2_v_reg <= p1_v_reg;
            mv_v_reg <= cmd.mv_rd;
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg  <= idx;
        p2_idx_reg  <= p1_idx_reg;
        p2_col_reg  <= rdc_reg;
        mv_addr_reg <= idx - AW'(1);
        if (p2_v_reg && ((p2_idx_reg == '0) || (psum < best_reg))) begin
            best_reg     <= psum;
            bi_reg       <= p2_idx_reg;
            best_col_reg <= p2_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            first_reg <= 1'b1;
        end else begin
            if (cmd.clr_first) begin
                first_reg <= 1'b0;
            end
            if (cmd.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end else if (cmd.append && !full) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // result
    assign unknown  = (col_reg == lmnu_pkg::COL_UNKNOWN_NEG) ||
                      (col_reg == lmnu_pkg::COL_UNKNOWN_POS);
    assign slot_cnt = SW'(count_reg);
    assign slot_bi  = SW'(bi_reg);
    assign tot_cnt  = TW'(count_reg);
    assign tot_inc  = TW'(count_reg) + TW'(1);
    assign ri_cmp   = TW'(ri_reg);
    assign rd_ok    = (ri_cmp < tot_cnt);

    always_comb begin
        res              = '0;
        res.entry_total  = tot_cnt[6:0];
        res.entry_colour = col_reg;
        case (cmd.act)
            lmnu_pkg::ACT_OOR: begin
                res.action = lmnu_pkg::ACT_OOR;
            end
            lmnu_pkg::ACT_DUP: begin
                res.action = lmnu_pkg::ACT_DUP;
                res.slot   = slot_bi[5:0];
                res.map_x  = gx_reg;
                res.map_y  = gy_reg;
            end
            lmnu_pkg::ACT_FRAME: begin
                res.action       = lmnu_pkg::ACT_FRAME;
                res.entry_colour = '0;
            end
            lmnu_pkg::ACT_READ: begin
                res.action       = lmnu_pkg::ACT_READ;
                res.slot         = ri_reg;
                res.entry_colour = '0;
                if (rd_ok) begin
                    res.entry_valid  = 1'b1;
                    res.map_x        = rdx_reg;
                    res.map_y        = rdy_reg;
                    res.entry_colour = dec_col(rdc_reg);
                end
            end
            lmnu_pkg::ACT_INS, lmnu_pkg::ACT_REP: begin
                res.map_x = gx_reg;
                res.map_y = gy_reg;
                if (full) begin
                    res.action = lmnu_pkg::ACT_FULL;
                end else begin
                    res.action      = cmd.act;
                    res.slot        = slot_cnt[5:0];
                    res.entry_total = tot_inc[6:0];
                end
            end
            default: begin
                res.action = cmd.act;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld || cmd.append) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld || cmd.append) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_payload    = out_reg;
    assign count        = count_reg;
    assign best_idx     = bi_reg;
    assign sts.oor      = (psum > 50'(range_sq));
    assign sts.match    = (best_reg <= 50'(match_sq));
    assign sts.dup      = (best_col_reg == col_reg[2:0]) || unknown;
    assign sts.busy     = p1_v_reg || p2_v_reg;
    assign sts.first    = first_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
endmodule
`default_nettype wire

FILE: rtl/lmnu_ctrl.sv
// Controller: sequences range check, transform, nearest scan, compaction and result.
`default_nettype none
module lmnu_ctrl #(
    parameter int MAP_DEPTH = lmnu_pkg::MAP_DEPTH_DEF,
    parameter int AW = $clog2(MAP_DEPTH),
    parameter int CW = $clog2(MAP_DEPTH + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_func,
    input  wire lmnu_pkg::lmnu_sts_t sts,
    input  wire logic [CW-1:0]       count,
    input  wire logic [AW-1:0]       best_idx,
    output lmnu_pkg::lmnu_cmd_t      cmd,
    output logic [AW-1:0]            idx
);
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RANGE  = 13'b0000000000010,
        ST_RCHK   = 13'b0000000000100,
        ST_ROT1   = 13'b0000000001000,
        ST_ROT2   = 13'b0000000010000,
        ST_SCAN   = 13'b0000000100000,
        ST_DRAIN  = 13'b0000001000000,
        ST_DECIDE = 13'b0000010000000,
        ST_SHIFT  = 13'b0000100000000,
        ST_DEC    = 13'b0001000000000,
        ST_APPEND = 13'b0010000000000,
        ST_RDRD   = 13'b0100000000000,
        ST_RES    = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    lmnu_pkg::lmnu_act_t act_reg, act_next;
    logic                last_idx;

    assign last_idx = ((CW'(idx_reg) + CW'(1)) == count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            act_reg   <= lmnu_pkg::ACT_OOR;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            act_reg   <= act_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        act_next   = act_reg;
        cmd        = '0;
        cmd.act    = act_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    case (s_func)
                        lmnu_pkg::FUNC_LANDMARK: state_next = ST_RANGE;
                        lmnu_pkg::FUNC_FRAME: begin
                            cmd.clr_first = 1'b1;
                            act_next      = lmnu_pkg::ACT_FRAME;
                            state_next    = ST_RES;
                        end
                        lmnu_pkg::FUNC_READ: state_next = ST_RDRD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RANGE: begin
                cmd.mul_op = lmnu_pkg::MUL_RANGE;
                state_next = ST_RCHK;
            end
            ST_RCHK: begin
                cmd.mul_op = lmnu_pkg::MUL_ROT1;
                if (sts.oor) begin
                    act_next   = lmnu_pkg::ACT_OOR;
                    state_next = ST_RES;
                end else begin
                    state_next = ST_ROT1;
                end
            end
            ST_ROT1: begin
                cmd.mul_op = lmnu_pkg::MUL_ROT2;
                cmd.gx_ld  = 1'b1;
                state_next = ST_ROT2;
            end
            ST_ROT2: begin
                cmd.gy_ld = 1'b1;
                idx_next  = '0;
                if (sts.first || (count == '0)) begin
                    act_next   = lmnu_pkg::ACT_INS;
                    state_next = ST_APPEND;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!sts.match) begin
                    act_next   = lmnu_pkg::ACT_INS;
                    state_next = ST_APPEND;
                end else if (sts.dup) begin
                    act_next   = lmnu_pkg::ACT_DUP;
                    state_next = ST_RES;
                end else begin
                    act_next = lmnu_pkg::ACT_REP;
                    idx_next = best_idx + AW'(1);
                    if ((CW'(best_idx) + CW'(1)) < count) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.mv_rd = 1'b1;
                if (last_idx) begin
                    state_next = ST_DEC;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DEC: begin
                cmd.cnt_dec = 1'b1;
                state_next  = ST_APPEND;
            end
            ST_APPEND: begin
                if (sts.out_free) begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RDRD: begin
                cmd.ri_rd  = 1'b1;
                act_next   = lmnu_pkg::ACT_READ;
                state_next = ST_RES;
            end
            ST_RES: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign idx = idx_reg;
endmodule
`default_nettype wire

FILE: rtl/landmark_map_nearest_update_unit.sv
// Top level of the landmark map nearest-update unit.
// One item is processed at a time. A landmark that is searched against the table goes
// through the range check, the two-step transform, the nearest search over the stored
// entries (one entry per cycle, set by the single read port of the entry memory) and the
// scan pipeline drain; when it replaces an entry, the entries above it are then moved
// down to compact the table. A first-frame landmark skips the search; an out-of-range
// landmark ends after the range check, and an unused function code gives no result. Each
// item that produces a result also waits while a previous result is held by the
// receiver. A new item is taken while the previous result still waits in the output
// register. The entry memory is not cleared at reset; only entries below the stored
// count are ever used.
`default_nettype none
module landmark_map_nearest_update_unit #(
    parameter int MAP_DEPTH = lmnu_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lmnu_pkg::lmnu_in_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lmnu_pkg::lmnu_out_t      m_payload,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);
    localparam int AW = $clog2(MAP_DEPTH);
    localparam int CW = $clog2(MAP_DEPTH + 1);

    lmnu_pkg::lmnu_cmd_t cmd;
    lmnu_pkg::lmnu_sts_t sts;
    logic [AW-1:0]       idx;
    logic [AW-1:0]       best_idx;
    logic [CW-1:0]       count;
    logic [31:0]         match_sq;
    logic [31:0]         range_sq;

    lmnu_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .match_sq (match_sq),
        .range_sq (range_sq)
    );

    lmnu_ctrl #(.MAP_DEPTH(MAP_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_payload.func),
        .sts      (sts),
        .count    (count),
        .best_idx (best_idx),
        .cmd      (cmd),
        .idx      (idx)
    );

    lmnu_dp #(.MAP_DEPTH(MAP_DEPTH), .AW(AW), .CW(CW)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_payload),
        .cmd       (cmd),
        .idx       (idx),
        .match_sq  (match_sq),
        .range_sq  (range_sq),
        .sts       (sts),
        .count     (count),
        .best_idx  (best_idx),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );
endmodule
`default_nettype wire

FILE: rtl/lmnu_checker.sv
// Port-level checker for the landmark map nearest-update unit, bound to the top level.
`default_nettype none
module lmnu_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire lmnu_pkg::lmnu_in_t  s_payload,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire lmnu_pkg::lmnu_out_t m_payload
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    a_valid_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.entry_valid |-> m_payload.action == lmnu_pkg::ACT_READ)
        else $error("entry_valid outside a read");

    a_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.action == lmnu_pkg::ACT_FRAME |->
        m_payload.slot == 6'd0 && m_payload.map_x == 24'sd0 && m_payload.map_y == 24'sd0)
        else $error("frame end result not cleared");

    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.action == lmnu_pkg::ACT_FULL ||
                    m_payload.action == lmnu_pkg::ACT_OOR) |-> m_payload.slot == 6'd0)
        else $error("dropped item reports a slot");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_payload.func <= lmnu_pkg::FUNC_READ) |=> !s_ready)
        else $error("second transaction taken during processing");
endmodule

bind landmark_map_nearest_update_unit lmnu_checker u_lmnu_checker (.*);
`default_nettype wire
